// ===== rtl/rrav_pkg.sv =====
package rrav_pkg;

    // Result mode codes.
    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_SLIDE   = 2'd1;
    localparam logic [1:0] MODE_REPULSE = 2'd2;

    // Number of range sensors on the ring.
    localparam int NSENS = 6;

    // Largest magnitude of a repulsion term or an axis sum.
    localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;

    // Q1.14 cosine of 30 degrees, and the Q1.14 fraction width.
    localparam logic [13:0] COS_30     = 14'd14189;
    localparam int          TRIG_SHIFT = 14;

    typedef struct packed {
        logic [15:0] range_front;
        logic [15:0] range_front_left;
        logic [15:0] range_left;
        logic [15:0] range_back;
        logic [15:0] range_right;
        logic [15:0] range_front_right;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } t_out_item;

    // Mode and slide velocity that ride beside the repulsion datapath.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] slide_x;
        logic signed [15:0] slide_y;
    } t_side;

    // Load enables of the pipeline stages before the output register, one per stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
        logic s8;
    } t_stage_en;

endpackage

// ===== rtl/range_ring_avoidance_velocity.sv =====
// Range-ring avoidance velocity. Each input transaction carries six unsigned
// fixed-point ranges (sensors at 0, 30, 90, 180, 270 and 330 degrees) and
// produces exactly one output transaction: a mode (clear, slide or repulse)
// and a signed x/y velocity command in the same fixed-point format. The block
// is a nine-stage pipeline: threshold compares and slide selection, error
// square, gain multiply, scaling with saturation, cosine scaling, three
// saturating accumulation stages, and the output register after speed
// shaping. It accepts one transaction every cycle unless its input is
// stalled, and each result passes through every stage in order. An output
// stall backs up through the pipeline bubble by bubble, so input stall only
// rises once every stage holds a result. Configuration registers sit on the
// APB port at byte addresses 0x00 through 0x1C and must only be written
// while the pipeline is empty.
module range_ring_avoidance_velocity #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  rrav_pkg::t_in_item    i_data,
    // Output channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output rrav_pkg::t_out_item   o_data,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_NEAR   = 3'd0;
    localparam logic [2:0] REG_DANGER = 3'd1;
    localparam logic [2:0] REG_SLIDE  = 3'd2;
    localparam logic [2:0] REG_GAIN   = 3'd3;
    localparam logic [2:0] REG_OFFSET = 3'd4;
    localparam logic [2:0] REG_MIN    = 3'd5;
    localparam logic [2:0] REG_MAX    = 3'd6;
    localparam logic [2:0] REG_DEAD   = 3'd7;

    localparam int NSTAGE = 9;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [15:0] r_near;
    logic [15:0] r_danger;
    logic [11:0] r_slide;
    logic [11:0] r_gain;
    logic [11:0] r_offset;
    logic [11:0] r_min;
    logic [11:0] r_max;
    logic [7:0]  r_dead;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= 16'd512;
            r_danger <= 16'd256;
            r_slide  <= 12'd128;
            r_gain   <= 12'd97;
            r_offset <= 12'd220;
            r_min    <= 12'd77;
            r_max    <= 12'd192;
            r_dead   <= 8'd3;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_NEAR:   r_near   <= pwdata[15:0];
                REG_DANGER: r_danger <= pwdata[15:0];
                REG_SLIDE:  r_slide  <= pwdata[11:0];
                REG_GAIN:   r_gain   <= pwdata[11:0];
                REG_OFFSET: r_offset <= pwdata[11:0];
                REG_MIN:    r_min    <= pwdata[11:0];
                REG_MAX:    r_max    <= pwdata[11:0];
                REG_DEAD:   r_dead   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read data is combinational; the access phase samples it.
    always_comb begin
        case (paddr[4:2])
            REG_NEAR:   prdata = {16'd0, r_near};
            REG_DANGER: prdata = {16'd0, r_danger};
            REG_SLIDE:  prdata = {20'd0, r_slide};
            REG_GAIN:   prdata = {20'd0, r_gain};
            REG_OFFSET: prdata = {20'd0, r_offset};
            REG_MIN:    prdata = {20'd0, r_min};
            REG_MAX:    prdata = {20'd0, r_max};
            REG_DEAD:   prdata = {24'd0, r_dead};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. Each stage loads when it is empty or when the stage
    // after it loads, so bubbles collapse under an output stall and no
    // transaction is dropped or repeated.
    // ------------------------------------------------------------------
    logic [NSTAGE:1]     r_vld;
    logic [NSTAGE:1]     n_vld;
    logic [NSTAGE:1]     rdy;
    rrav_pkg::t_stage_en en;

    always_comb begin
        rdy[NSTAGE] = !r_vld[NSTAGE] || !i_stall;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[1] = rdy[1] ? i_valid : r_vld[1];
        for (int k = 2; k <= NSTAGE; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign en.s1 = rdy[1];
    assign en.s2 = rdy[2];
    assign en.s3 = rdy[3];
    assign en.s4 = rdy[4];
    assign en.s5 = rdy[5];
    assign en.s6 = rdy[6];
    assign en.s7 = rdy[7];
    assign en.s8 = rdy[8];

    assign o_stall = !rdy[1];

    // ------------------------------------------------------------------
    // Datapath.
    // ------------------------------------------------------------------
    logic [rrav_pkg::NSENS-1:0][16:0] abs_err;
    logic [rrav_pkg::NSENS-1:0]       hit;
    rrav_pkg::t_side                  side1;
    logic [rrav_pkg::NSENS-1:0][30:0] mag;
    logic [30:0]                      p1;
    logic [30:0]                      p5;
    logic signed [15:0]               rep_x;
    logic signed [15:0]               rep_y;

    rrav_front u_front (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_data    (i_data),
        .i_near    (r_near),
        .i_danger  (r_danger),
        .i_slide   (r_slide),
        .i_offset  (r_offset),
        .o_abs_err (abs_err),
        .o_hit     (hit),
        .o_side    (side1)
    );

    rrav_mag #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mag (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_abs_err (abs_err),
        .i_hit     (hit),
        .i_gain    (r_gain),
        .o_mag     (mag),
        .o_p1      (p1),
        .o_p5      (p5)
    );

    rrav_accum u_accum (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mag   (mag),
        .i_p1    (p1),
        .i_p5    (p5),
        .i_max   (r_max),
        .i_min   (r_min),
        .i_dead  (r_dead),
        .o_vel_x (rep_x),
        .o_vel_y (rep_y)
    );

    // The mode and the slide command travel alongside the repulsion math so
    // that they meet it again at the output register.
    rrav_pkg::t_side r_side [2:NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (rdy[2]) r_side[2] <= side1;
        for (int k = 3; k <= NSTAGE - 1; k++) begin
            if (rdy[k]) r_side[k] <= r_side[k-1];
        end
    end

    // Output register: pick the command that matches the mode.
    rrav_pkg::t_out_item r_out;
    rrav_pkg::t_out_item n_out;

    always_comb begin
        n_out.mode = r_side[NSTAGE-1].mode;
        case (r_side[NSTAGE-1].mode)
            rrav_pkg::MODE_CLEAR: begin
                n_out.vel_x = '0;
                n_out.vel_y = '0;
            end
            rrav_pkg::MODE_SLIDE: begin
                n_out.vel_x = r_side[NSTAGE-1].slide_x;
                n_out.vel_y = r_side[NSTAGE-1].slide_y;
            end
            rrav_pkg::MODE_REPULSE: begin
                n_out.vel_x = rep_x;
                n_out.vel_y = rep_y;
            end
            default: begin
                n_out.vel_x = '0;
                n_out.vel_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NSTAGE]) r_out <= n_out;
    end

    assign o_valid = r_vld[NSTAGE];
    assign o_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input side only stalls when every stage holds a transaction.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while the pipeline has a bubble");

    // A clear result carries no velocity.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.mode == rrav_pkg::MODE_CLEAR)
            |-> (o_data.vel_x == 16'sd0 && o_data.vel_y == 16'sd0))
        else $error("clear result with nonzero velocity");

    // A slide result moves along one axis at most.
    a_slide_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.mode == rrav_pkg::MODE_SLIDE)
            |-> (o_data.vel_x == 16'sd0 || o_data.vel_y == 16'sd0))
        else $error("slide result moves on both axes");

endmodule

// ===== rtl/rrav_front.sv =====
module rrav_front (
    input  logic                            i_clk,
    input  rrav_pkg::t_stage_en             i_en,
    input  rrav_pkg::t_in_item              i_data,
    input  logic [15:0]                     i_near,
    input  logic [15:0]                     i_danger,
    input  logic [11:0]                     i_slide,
    input  logic [11:0]                     i_offset,
    output logic [rrav_pkg::NSENS-1:0][16:0] o_abs_err,
    output logic [rrav_pkg::NSENS-1:0]       o_hit,
    output rrav_pkg::t_side                 o_side
);

    logic [rrav_pkg::NSENS-1:0][15:0] d;
    logic [rrav_pkg::NSENS-1:0][16:0] n_abs;
    logic [rrav_pkg::NSENS-1:0]       n_hit;
    logic [rrav_pkg::NSENS-1:0]       far;
    logic [rrav_pkg::NSENS-1:0]       safe;
    logic [rrav_pkg::NSENS-1:0]       below;
    logic [16:0]                      ref_lvl;
    logic signed [15:0]               spd;
    logic signed [15:0]               sx;
    logic signed [15:0]               sy;
    rrav_pkg::t_side                  n_side;

    logic [rrav_pkg::NSENS-1:0][16:0] r_abs;
    logic [rrav_pkg::NSENS-1:0]       r_hit;
    rrav_pkg::t_side                  r_side;

    // Sensor order: front, front-left, left, back, right, front-right.
    assign d[0] = i_data.range_front;
    assign d[1] = i_data.range_front_left;
    assign d[2] = i_data.range_left;
    assign d[3] = i_data.range_back;
    assign d[4] = i_data.range_right;
    assign d[5] = i_data.range_front_right;

    assign ref_lvl = {1'b0, i_danger} + {5'd0, i_offset};
    assign spd     = $signed({4'd0, i_slide});

    always_comb begin
        for (int i = 0; i < rrav_pkg::NSENS; i++) begin
            far[i]   = d[i] > i_near;
            safe[i]  = d[i] > i_danger;
            below[i] = d[i] < i_near;
            n_hit[i] = d[i] < i_danger;
            if ({1'b0, d[i]} >= ref_lvl) begin
                n_abs[i] = {1'b0, d[i]} - ref_lvl;
            end else begin
                n_abs[i] = ref_lvl - {1'b0, d[i]};
            end
        end
    end

    // Slide priority chain: the first near sensor picks two escape directions.
    always_comb begin
        sx = '0;
        sy = '0;
        if (below[0]) begin
            if (far[4]) sy = -spd;
            else if (far[2]) sy = spd;
        end else if (below[4]) begin
            if (far[0]) sx = spd;
            else if (far[3]) sx = -spd;
        end else if (below[2]) begin
            if (far[0]) sx = spd;
            else if (far[3]) sx = -spd;
        end else if (below[1]) begin
            if (far[4]) sy = -spd;
            else if (far[3]) sx = -spd;
        end else if (below[5]) begin
            if (far[2]) sy = spd;
            else if (far[3]) sx = -spd;
        end else if (below[3]) begin
            if (far[2]) sy = spd;
            else if (far[4]) sy = -spd;
        end
    end

    always_comb begin
        n_side.slide_x = sx;
        n_side.slide_y = sy;
        if (&far) begin
            n_side.mode = rrav_pkg::MODE_CLEAR;
        end else if (&safe) begin
            n_side.mode = rrav_pkg::MODE_SLIDE;
        end else begin
            n_side.mode = rrav_pkg::MODE_REPULSE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_abs  <= n_abs;
            r_hit  <= n_hit;
            r_side <= n_side;
        end
    end

    assign o_abs_err = r_abs;
    assign o_hit     = r_hit;
    assign o_side    = r_side;

endmodule

// ===== rtl/rrav_mag.sv =====
module rrav_mag #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  rrav_pkg::t_stage_en              i_en,
    input  logic [rrav_pkg::NSENS-1:0][16:0] i_abs_err,
    input  logic [rrav_pkg::NSENS-1:0]       i_hit,
    input  logic [11:0]                      i_gain,
    output logic [rrav_pkg::NSENS-1:0][30:0] o_mag,
    output logic [30:0]                      o_p1,
    output logic [30:0]                      o_p5
);

    localparam int SHIFT = 2 * FRAC_BITS;

    logic [rrav_pkg::NSENS-1:0][33:0] n_sq;
    logic [rrav_pkg::NSENS-1:0][45:0] n_prod;
    logic [rrav_pkg::NSENS-1:0][45:0] scaled;
    logic [rrav_pkg::NSENS-1:0][30:0] n_mag4;
    logic [44:0]                      cp1;
    logic [44:0]                      cp5;

    logic [rrav_pkg::NSENS-1:0][33:0] r_sq;
    logic [rrav_pkg::NSENS-1:0][45:0] r_prod;
    logic [rrav_pkg::NSENS-1:0][30:0] r_mag4;
    logic [rrav_pkg::NSENS-1:0][30:0] r_mag5;
    logic [30:0]                      r_p1;
    logic [30:0]                      r_p5;

    always_comb begin
        for (int i = 0; i < rrav_pkg::NSENS; i++) begin
            if (i_hit[i]) begin
                n_sq[i] = {17'd0, i_abs_err[i]} * {17'd0, i_abs_err[i]};
            end else begin
                n_sq[i] = '0;
            end
            n_prod[i] = {12'd0, r_sq[i]} * {34'd0, i_gain};
            scaled[i] = r_prod[i] >> SHIFT;
            if (scaled[i] > {15'd0, rrav_pkg::ACC_MAX}) begin
                n_mag4[i] = rrav_pkg::ACC_MAX;
            end else begin
                n_mag4[i] = scaled[i][30:0];
            end
        end
    end

    // The 30 degree lanes scale by the Q1.14 cosine; the rest pass unchanged.
    assign cp1 = {14'd0, r_mag4[1]} * {31'd0, rrav_pkg::COS_30};
    assign cp5 = {14'd0, r_mag4[5]} * {31'd0, rrav_pkg::COS_30};

    always_ff @(posedge i_clk) begin
        if (i_en.s2) r_sq <= n_sq;
        if (i_en.s3) r_prod <= n_prod;
        if (i_en.s4) r_mag4 <= n_mag4;
        if (i_en.s5) begin
            r_mag5 <= r_mag4;
            r_p1   <= cp1[rrav_pkg::TRIG_SHIFT +: 31];
            r_p5   <= cp5[rrav_pkg::TRIG_SHIFT +: 31];
        end
    end

    assign o_mag = r_mag5;
    assign o_p1  = r_p1;
    assign o_p5  = r_p5;

endmodule

// ===== rtl/rrav_accum.sv =====
module rrav_accum (
    input  logic                             i_clk,
    input  rrav_pkg::t_stage_en              i_en,
    input  logic [rrav_pkg::NSENS-1:0][30:0] i_mag,
    input  logic [30:0]                      i_p1,
    input  logic [30:0]                      i_p5,
    input  logic [11:0]                      i_max,
    input  logic [11:0]                      i_min,
    input  logic [7:0]                       i_dead,
    output logic signed [15:0]               o_vel_x,
    output logic signed [15:0]               o_vel_y
);

    localparam logic signed [32:0] LIM = $signed({2'b00, rrav_pkg::ACC_MAX});

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [32:0] r;
        if (v > LIM) begin
            r = LIM;
        end else if (v < -LIM) begin
            r = -LIM;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    function automatic logic signed [33:0] ext(input logic signed [31:0] v);
        return {v[31], v[31], v};
    endfunction

    function automatic logic signed [32:0] up(input logic [30:0] m);
        return $signed({2'b00, m});
    endfunction

    // Clamp to the largest speed, then lift small values above the dead band to the smallest.
    function automatic logic signed [15:0] shape(input logic signed [31:0] v,
                                                 input logic [11:0] vmax,
                                                 input logic [11:0] vmin,
                                                 input logic [7:0]  dead);
        logic [30:0] a;
        logic [11:0] m;
        logic [15:0] u;
        a = v[31] ? 31'(-v) : v[30:0];
        if (a > {19'd0, vmax}) begin
            m = vmax;
        end else begin
            m = a[11:0];
        end
        if (m < vmin && m > {4'd0, dead}) begin
            m = vmin;
        end
        u = {4'd0, m};
        return v[31] ? -$signed(u) : $signed(u);
    endfunction

    logic signed [31:0] r_ax6;
    logic signed [31:0] r_by6;
    logic [30:0]        r_m3_6;
    logic [30:0]        r_m4_6;
    logic [30:0]        r_p5_6;
    logic [30:0]        r_h5_6;
    logic signed [31:0] r_ax7;
    logic signed [31:0] r_by7;
    logic [30:0]        r_p5_7;
    logic [30:0]        r_h5_7;
    logic signed [31:0] r_ax8;
    logic signed [31:0] r_by8;

    logic signed [31:0] n_ax6;
    logic signed [31:0] n_by6;
    logic signed [31:0] n_ax7;
    logic signed [31:0] n_by7;
    logic signed [31:0] n_ax8;
    logic signed [31:0] n_by8;

    // X terms: front pushes back, front-left and front-right push back by
    // the cosine share, back pushes forward. Y terms: front-left and
    // front-right by half, left and right by the full magnitude.
    assign n_ax6 = sat33(33'sd0 - up(i_mag[0]) - up(i_p1));
    assign n_by6 = sat33(33'sd0 - up({1'b0, i_mag[1][30:1]}) - up(i_mag[2]));
    assign n_ax7 = sat33(33'(ext(r_ax6) + up(r_m3_6)));
    assign n_by7 = sat33(33'(ext(r_by6) + up(r_m4_6)));
    assign n_ax8 = sat33(33'(ext(r_ax7) - up(r_p5_7)));
    assign n_by8 = sat33(33'(ext(r_by7) + up(r_h5_7)));

    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            r_ax6  <= n_ax6;
            r_by6  <= n_by6;
            r_m3_6 <= i_mag[3];
            r_m4_6 <= i_mag[4];
            r_p5_6 <= i_p5;
            r_h5_6 <= {1'b0, i_mag[5][30:1]};
        end
        if (i_en.s7) begin
            r_ax7  <= n_ax7;
            r_by7  <= n_by7;
            r_p5_7 <= r_p5_6;
            r_h5_7 <= r_h5_6;
        end
        if (i_en.s8) begin
            r_ax8 <= n_ax8;
            r_by8 <= n_by8;
        end
    end

    assign o_vel_x = shape(r_ax8, i_max, i_min, i_dead);
    assign o_vel_y = shape(r_by8, i_max, i_min, i_dead);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Bench for the range-ring avoidance velocity block.
//
// Every accepted input transaction gets its expected command worked out at
// the moment of acceptance and queued. The output monitor pops the oldest
// expected command for every accepted output transaction and compares the
// mode and both velocity fields.
//
// The run has three parts:
//   * a short directed table, walked at the register values after reset;
//   * eight random blocks, each preceded by a full register load while the
//     pipeline is empty;
//   * a final drain, after which the verdict is printed.
//
// Both channels idle at random. The first blocks idle mostly on the output
// side, the middle blocks mostly on the input side, and the last blocks not
// at all. In one of the last blocks the receiver also holds off for a long
// stretch, so the pipeline fills up and the block has to stall its input.
module tb_top;

    localparam int FRAC_BITS       = 8;
    localparam int CLK_HALF        = 1;
    localparam int RESET_CYCLES    = 5;
    // The pipeline is nine stages deep, so this leaves some margin.
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_BLOCKS   = 8;
    localparam int BLOCK_ITEMS     = 153;
    localparam int PRESSURE_BLOCK  = 6;
    localparam int HOLD_CYCLES     = 80;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DIRECTED_ROWS   = 25;
    localparam longint SUM_LIMIT   = longint'(rrav_pkg::ACC_MAX);

    // Sensor positions in the ring, in the order of the input fields.
    localparam int S_FRONT       = 0;
    localparam int S_FRONT_LEFT  = 1;
    localparam int S_LEFT        = 2;
    localparam int S_BACK        = 3;
    localparam int S_RIGHT       = 4;
    localparam int S_FRONT_RIGHT = 5;

    // Q1.14 direction of each sensor, in the same order.
    localparam int DIR_COS [rrav_pkg::NSENS] = '{16384, 14189, 0, -16384, 0, 14189};
    localparam int DIR_SIN [rrav_pkg::NSENS] = '{0, 8192, 16384, 0, -16384, -8192};

    // Register indexes on the configuration port.
    typedef enum int {
        REG_NEAR   = 0,
        REG_DANGER = 1,
        REG_SLIDE  = 2,
        REG_GAIN   = 3,
        REG_OFFSET = 4,
        REG_MIN    = 5,
        REG_MAX    = 6,
        REG_DEAD   = 7
    } t_cfg_reg;

    // One complete register setting, in register order.
    typedef struct packed {
        logic [15:0] near_thr;
        logic [15:0] danger_thr;
        logic [11:0] slide_spd;
        logic [11:0] gain;
        logic [11:0] rep_offset;
        logic [11:0] min_spd;
        logic [11:0] max_spd;
        logic [7:0]  dead_band;
    } t_cfg;

    // One row of the directed table. Where known is set, want is the
    // command read straight off the behavior; otherwise it is predicted.
    typedef struct packed {
        rrav_pkg::t_in_item  ranges;
        logic                known;
        rrav_pkg::t_out_item want;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    rrav_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_stall;
    rrav_pkg::t_out_item o_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [4:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Register values the block should hold right now.
    t_cfg                live_cfg;
    t_cfg                settings [RANDOM_BLOCKS];
    t_dir_row            dir_tab [DIRECTED_ROWS];

    // Commands the block still owes, oldest first.
    rrav_pkg::t_out_item pending_cmds [$];
    rrav_pkg::t_out_item next_cmd;

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          fail_count;
    int          quiet_cycles;

    range_ring_avoidance_velocity #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Sums of repulsion terms saturate symmetrically at the accumulator limit.
    function automatic longint clip_sum(longint v);
        if (v > SUM_LIMIT) return SUM_LIMIT;
        if (v < -SUM_LIMIT) return -SUM_LIMIT;
        return v;
    endfunction

    // A sensor pushes away from its own direction, so the term carries the
    // opposite sign of the direction component.
    function automatic longint dir_push(longint mag, int c);
        longint ac;
        longint p;
        ac = (c < 0) ? -c : c;
        p  = (mag * ac) >>> rrav_pkg::TRIG_SHIFT;
        return (c < 0) ? p : -p;
    endfunction

    // Clamp to the top speed first, then raise small but non-negligible
    // speeds to the floor. The raise wins when the floor exceeds the top.
    function automatic longint shape_axis(longint v);
        longint a;
        a = (v < 0) ? -v : v;
        if (a > longint'(live_cfg.max_spd)) a = longint'(live_cfg.max_spd);
        if (a < longint'(live_cfg.min_spd) && a > longint'(live_cfg.dead_band))
            a = longint'(live_cfg.min_spd);
        return (v < 0) ? -a : a;
    endfunction

    function automatic rrav_pkg::t_out_item predict_command(rrav_pkg::t_in_item r);
        logic [15:0]         d [rrav_pkg::NSENS];
        logic [15:0]         n;
        bit                  all_far;
        bit                  all_safe;
        longint              vx;
        longint              vy;
        longint              s;
        longint              base;
        longint              e;
        longint              mag;
        logic [63:0]         sq;
        logic [63:0]         scaled;
        rrav_pkg::t_out_item cmd;
        d = '{r.range_front, r.range_front_left, r.range_left,
              r.range_back, r.range_right, r.range_front_right};
        n        = live_cfg.near_thr;
        s        = longint'(live_cfg.slide_spd);
        all_far  = 1'b1;
        all_safe = 1'b1;
        vx       = 0;
        vy       = 0;
        for (int i = 0; i < rrav_pkg::NSENS; i++) begin
            if (d[i] <= live_cfg.near_thr) all_far = 1'b0;
            if (d[i] <= live_cfg.danger_thr) all_safe = 1'b0;
        end
        if (all_far) begin
            cmd.mode = rrav_pkg::MODE_CLEAR;
        end else if (all_safe) begin
            // The first near sensor in priority order picks two escape
            // directions; a range equal to the threshold is neither near
            // nor free.
            cmd.mode = rrav_pkg::MODE_SLIDE;
            if (d[S_FRONT] < n) begin
                if (d[S_RIGHT] > n) vy = -s;
                else if (d[S_LEFT] > n) vy = s;
            end else if (d[S_RIGHT] < n) begin
                if (d[S_FRONT] > n) vx = s;
                else if (d[S_BACK] > n) vx = -s;
            end else if (d[S_LEFT] < n) begin
                if (d[S_FRONT] > n) vx = s;
                else if (d[S_BACK] > n) vx = -s;
            end else if (d[S_FRONT_LEFT] < n) begin
                if (d[S_RIGHT] > n) vy = -s;
                else if (d[S_BACK] > n) vx = -s;
            end else if (d[S_FRONT_RIGHT] < n) begin
                if (d[S_LEFT] > n) vy = s;
                else if (d[S_BACK] > n) vx = -s;
            end else if (d[S_BACK] < n) begin
                if (d[S_LEFT] > n) vy = s;
                else if (d[S_RIGHT] > n) vy = -s;
            end
        end else begin
            cmd.mode = rrav_pkg::MODE_REPULSE;
            base = longint'(live_cfg.danger_thr) + longint'(live_cfg.rep_offset);
            for (int i = 0; i < rrav_pkg::NSENS; i++) begin
                if (d[i] < live_cfg.danger_thr) begin
                    e      = longint'(d[i]) - base;
                    sq     = e * e;
                    scaled = (sq * live_cfg.gain) >> (2 * FRAC_BITS);
                    mag    = (scaled > SUM_LIMIT) ? SUM_LIMIT : longint'(scaled);
                    vx     = clip_sum(vx + dir_push(mag, DIR_COS[i]));
                    vy     = clip_sum(vy + dir_push(mag, DIR_SIN[i]));
                end
            end
            vx = shape_axis(vx);
            vy = shape_axis(vy);
        end
        cmd.vel_x = 16'(vx);
        cmd.vel_y = 16'(vy);
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // A range between lo and hi, clipped to the field; an empty interval
    // falls back to any value at all.
    function automatic logic [15:0] range_in(int lo, int hi);
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        if (lo > hi) return 16'($urandom_range(65535));
        return 16'($urandom_range(hi, lo));
    endfunction

    // Most transactions aim at one of the three modes, with ranges gathered
    // around the thresholds that decide it. The rest are noise.
    function automatic rrav_pkg::t_in_item random_ranges();
        logic [15:0] d [rrav_pkg::NSENS];
        int          near_v;
        int          danger_v;
        int          aim;
        int          k;
        near_v   = int'(live_cfg.near_thr);
        danger_v = int'(live_cfg.danger_thr);
        aim      = $urandom_range(9);
        for (int i = 0; i < rrav_pkg::NSENS; i++) begin
            k = $urandom_range(9);
            if (aim < 3) begin
                d[i] = range_in(near_v + 1, 65535);
            end else if (aim < 6) begin
                if (k < 3) d[i] = range_in(danger_v + 1, near_v - 1);
                else if (k == 3) d[i] = 16'(near_v);
                else if (k < 6) d[i] = range_in(near_v - 4, near_v + 4);
                else d[i] = range_in(near_v + 1, 65535);
            end else if (aim < 9) begin
                if (k < 3) d[i] = range_in(0, danger_v - 1);
                else if (k == 3) d[i] = 16'(danger_v);
                else if (k == 4) d[i] = range_in(danger_v - 300, danger_v + 300);
                else d[i] = range_in(danger_v + 1, 65535);
            end else begin
                if (k < 2) d[i] = 16'd0;
                else if (k < 4) d[i] = 16'hFFFF;
                else d[i] = 16'($urandom_range(65535));
            end
        end
        return '{d[0], d[1], d[2], d[3], d[4], d[5]};
    endfunction

    function automatic t_cfg random_setting();
        t_cfg c;
        c.near_thr   = 16'($urandom_range(4000));
        c.danger_thr = 16'($urandom_range(int'(c.near_thr)));
        c.slide_spd  = 12'($urandom_range(4095));
        c.gain       = 12'($urandom_range(4095));
        c.rep_offset = 12'($urandom_range(4095));
        c.min_spd    = 12'($urandom_range(300));
        c.max_spd    = 12'($urandom_range(4095));
        c.dead_band  = 8'($urandom_range(255));
        return c;
    endfunction

    // One register write: a setup phase, then an access phase. The register
    // takes the value at the edge that ends the access phase.
    task automatic cfg_write(t_cfg_reg idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_NEAR:   live_cfg.near_thr   = value[15:0];
            REG_DANGER: live_cfg.danger_thr = value[15:0];
            REG_SLIDE:  live_cfg.slide_spd  = value[11:0];
            REG_GAIN:   live_cfg.gain       = value[11:0];
            REG_OFFSET: live_cfg.rep_offset = value[11:0];
            REG_MIN:    live_cfg.min_spd    = value[11:0];
            REG_MAX:    live_cfg.max_spd    = value[11:0];
            REG_DEAD:   live_cfg.dead_band  = value[7:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(t_cfg s);
        cfg_write(REG_NEAR,   32'(s.near_thr));
        cfg_write(REG_DANGER, 32'(s.danger_thr));
        cfg_write(REG_SLIDE,  32'(s.slide_spd));
        cfg_write(REG_GAIN,   32'(s.gain));
        cfg_write(REG_OFFSET, 32'(s.rep_offset));
        cfg_write(REG_MIN,    32'(s.min_spd));
        cfg_write(REG_MAX,    32'(s.max_spd));
        cfg_write(REG_DEAD,   32'(s.dead_band));
    endtask

    // Wait until every owed command has come out, then let the pipeline
    // settle before anything else happens.
    task automatic drain_pipeline();
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offer one set of ranges and hold it until the block takes it. The
    // expected command is queued at the accepting edge.
    task automatic send_ranges(rrav_pkg::t_in_item r, bit known,
                               rrav_pkg::t_out_item want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (o_stall);
        pending_cmds.push_back(known ? want : predict_command(r));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        hold_req    = 1'b0;
        fail_count  = 0;
        tx_idle_pct = 27;
        rx_idle_pct = 81;
        live_cfg    = '{16'd512, 16'd256, 12'd128, 12'd97, 12'd220,
                        12'd77, 12'd192, 8'd3};

        // Register settings of the random blocks: the values after reset,
        // both extremes, a floor above the top speed with a huge gain, a
        // danger threshold above the near one, and random ones.
        settings[0] = live_cfg;
        settings[1] = '{16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                        12'hFFF, 12'hFFF, 8'hFF};
        settings[2] = '0;
        settings[3] = '{16'd2048, 16'd1024, 12'hFFF, 12'hFFF, 12'd0,
                        12'hFFF, 12'd100, 8'd0};
        settings[4] = random_setting();
        settings[5] = '{16'd300, 16'd600, 12'd1, 12'd1, 12'hFFF,
                        12'd1, 12'hFFF, 8'hFF};
        settings[6] = random_setting();
        settings[7] = random_setting();

        // Directed table at the register values after reset: near 512,
        // danger 256, slide speed 128. A near range is 300, a free one is
        // 1000 and 512 sits exactly on the near threshold.
        dir_tab = '{
            '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
              1'b1, '{rrav_pkg::MODE_CLEAR, 16'sd0, 16'sd0}},
            '{'{16'd513, 16'd513, 16'd513, 16'd513, 16'd513, 16'd513},
              1'b1, '{rrav_pkg::MODE_CLEAR, 16'sd0, 16'sd0}},
            '{'{16'd512, 16'd512, 16'd512, 16'd512, 16'd512, 16'd512},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, 16'sd0}},
            '{'{16'd256, 16'd256, 16'd256, 16'd256, 16'd256, 16'd256},
              1'b1, '{rrav_pkg::MODE_REPULSE, 16'sd0, 16'sd0}},
            '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
            '{'{16'd300, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, -16'sd128}},
            '{'{16'd300, 16'd1000, 16'd1000, 16'd1000, 16'd300, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, 16'sd128}},
            '{'{16'd300, 16'd1000, 16'd300, 16'd1000, 16'd300, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, 16'sd0}},
            '{'{16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd300, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd128, 16'sd0}},
            '{'{16'd512, 16'd1000, 16'd1000, 16'd1000, 16'd300, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, -16'sd128, 16'sd0}},
            '{'{16'd1000, 16'd1000, 16'd300, 16'd1000, 16'd1000, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd128, 16'sd0}},
            '{'{16'd512, 16'd1000, 16'd300, 16'd1000, 16'd1000, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, -16'sd128, 16'sd0}},
            '{'{16'd1000, 16'd300, 16'd1000, 16'd1000, 16'd1000, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, -16'sd128}},
            '{'{16'd1000, 16'd300, 16'd1000, 16'd1000, 16'd512, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, -16'sd128, 16'sd0}},
            '{'{16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd300},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, 16'sd128}},
            '{'{16'd1000, 16'd1000, 16'd512, 16'd1000, 16'd1000, 16'd300},
              1'b1, '{rrav_pkg::MODE_SLIDE, -16'sd128, 16'sd0}},
            '{'{16'd1000, 16'd1000, 16'd1000, 16'd300, 16'd1000, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, 16'sd128}},
            '{'{16'd1000, 16'd1000, 16'd512, 16'd300, 16'd1000, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, -16'sd128}},
            '{'{16'd1000, 16'd1000, 16'd512, 16'd300, 16'd512, 16'd1000},
              1'b1, '{rrav_pkg::MODE_SLIDE, 16'sd0, 16'sd0}},
            '{'{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
              1'b0, '0},
            '{'{16'd255, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000},
              1'b0, '0},
            '{'{16'd256, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000},
              1'b1, '{rrav_pkg::MODE_REPULSE, 16'sd0, 16'sd0}},
            '{'{16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd0, 16'd1000},
              1'b0, '0},
            '{'{16'd0, 16'd1000, 16'd1000, 16'd0, 16'd1000, 16'd1000},
              1'b0, '0},
            '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
              1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The directed rows run on the reset values of the registers, so
        // they also show that reset loaded them.
        foreach (dir_tab[i])
            send_ranges(dir_tab[i].ranges, dir_tab[i].known, dir_tab[i].want);
        i_valid <= 1'b0;

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            if (blk < 3) begin
                tx_idle_pct = 27;
                rx_idle_pct = 81;
            end else if (blk < 6) begin
                tx_idle_pct = 81;
                rx_idle_pct = 27;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            drain_pipeline();
            load_setting(settings[blk]);
            // The receiver holds off while transactions keep coming, so the
            // pipeline fills and the input stall has to rise.
            if (blk == PRESSURE_BLOCK) hold_req = 1'b1;
            repeat (BLOCK_ITEMS) send_ranges(random_ranges(), 1'b0, '0);
            i_valid <= 1'b0;
        end

        drain_pipeline();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, or one long hold-off when asked for
    // ------------------------------------------------------------------
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output check: every accepted output transaction against the oldest
    // expected command
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("output transaction with no command expected");
                fail_count++;
            end else begin
                next_cmd = pending_cmds.pop_front();
                if (o_data.mode !== next_cmd.mode) begin
                    $error("mode mismatch: expected %0d, got %0d",
                           next_cmd.mode, o_data.mode);
                    fail_count++;
                end
                if (o_data.vel_x !== next_cmd.vel_x) begin
                    $error("vel_x mismatch: expected %0d, got %0d",
                           next_cmd.vel_x, o_data.vel_x);
                    fail_count++;
                end
                if (o_data.vel_y !== next_cmd.vel_y) begin
                    $error("vel_y mismatch: expected %0d, got %0d",
                           next_cmd.vel_y, o_data.vel_y);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction on either channel ends
    // the run as a failure.
    // ------------------------------------------------------------------
    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
rtl/rrav_pkg.sv
rtl/rrav_front.sv
rtl/rrav_mag.sv
rtl/rrav_accum.sv
rtl/range_ring_avoidance_velocity.sv
bench/tb_top.sv
